// ===== design/segi_pkg.sv =====
// Shared types and constants for the segment intersection block.
`default_nettype none

package segi_pkg;

    // Configuration register file.
    localparam int REG_W     = 34;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH_SQ = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_CROSS_ABS = 1'd1;

    // Result status codes.
    typedef logic [1:0] status_t;
    localparam status_t ST_NONE    = 2'd0;
    localparam status_t ST_OUTSIDE = 2'd1;
    localparam status_t ST_CROSS   = 2'd2;

    // Quotient bits produced by the divider; anything above BIG_LIMIT saturates.
    localparam int QUOT_W = 41;
    localparam logic [QUOT_W-1:0] BIG_LIMIT = 41'h100_0000_0000;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;

endpackage

`default_nettype wire

// ===== design/segi_front.sv =====
// Front part: takes segment pairs, forms cross products and flags degenerate pairs.
`default_nettype none

module segi_front #(
    parameter int W = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [segi_pkg::REG_W-1:0]    min_length_sq,
    input  wire logic [segi_pkg::REG_W-1:0]    min_cross_abs,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [W-1:0]           s_a_start_x,
    input  wire logic signed [W-1:0]           s_a_start_y,
    input  wire logic signed [W-1:0]           s_a_end_x,
    input  wire logic signed [W-1:0]           s_a_end_y,
    input  wire logic signed [W-1:0]           s_b_start_x,
    input  wire logic signed [W-1:0]           s_b_start_y,
    input  wire logic signed [W-1:0]           s_b_end_x,
    input  wire logic signed [W-1:0]           s_b_end_y,
    output logic                               q_valid,
    input  wire logic                          q_ready,
    output logic signed [W-1:0]                e_ax0,
    output logic signed [W-1:0]                e_ay0,
    output logic signed [W:0]                  e_dax,
    output logic signed [W:0]                  e_day,
    output logic signed [2*W+2:0]              e_cr,
    output logic signed [2*W+2:0]              e_tn,
    output logic signed [2*W+2:0]              e_un,
    output logic                               e_degen
);
    import segi_pkg::*;

    localparam int DW = W + 1;
    localparam int PW = 2 * W + 2;
    localparam int XW = 2 * W + 3;
    localparam int LW = 2 * W + 2;
    localparam int CW = (LW > REG_W) ? LW : REG_W;

    logic adv;

    // Stage 1: differences.
    logic                 f1_v_reg;
    logic signed [DW-1:0] f1_dax_reg, f1_day_reg, f1_dbx_reg, f1_dby_reg, f1_dx_reg, f1_dy_reg;
    logic signed [W-1:0]  f1_ax0_reg, f1_ay0_reg;

    // Stage 2: products.
    logic                 f2_v_reg;
    logic [2*W:0]         f2_sqax_reg, f2_sqay_reg, f2_sqbx_reg, f2_sqby_reg;
    logic signed [PW-1:0] f2_c1_reg, f2_c2_reg, f2_t1_reg, f2_t2_reg, f2_u1_reg, f2_u2_reg;
    logic signed [W-1:0]  f2_ax0_reg, f2_ay0_reg;
    logic signed [DW-1:0] f2_dax_reg, f2_day_reg;

    // Stage 3: sums and classification.
    logic                 f3_v_reg;
    logic signed [XW-1:0] f3_cr_reg, f3_tn_reg, f3_un_reg;
    logic signed [W-1:0]  f3_ax0_reg, f3_ay0_reg;
    logic signed [DW-1:0] f3_dax_reg, f3_day_reg;
    logic                 f3_degen_reg;

    logic signed [PW-1:0] sqax_full, sqay_full, sqbx_full, sqby_full;
    logic [LW-1:0]        len_a, len_b;
    logic signed [XW-1:0] cr_next, tn_next, un_next, cr_neg;
    logic [LW-1:0]        cr_abs;
    logic                 degen_next;

    assign adv     = !f3_v_reg || q_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            f3_v_reg <= 1'b0;
        end else if (adv) begin
            f1_v_reg <= s_valid;
            f2_v_reg <= f1_v_reg;
            f3_v_reg <= f2_v_reg;
        end
    end

    assign sqax_full = f1_dax_reg * f1_dax_reg;
    assign sqay_full = f1_day_reg * f1_day_reg;
    assign sqbx_full = f1_dbx_reg * f1_dbx_reg;
    assign sqby_full = f1_dby_reg * f1_dby_reg;

    assign len_a   = LW'(f2_sqax_reg) + LW'(f2_sqay_reg);
    assign len_b   = LW'(f2_sqbx_reg) + LW'(f2_sqby_reg);
    assign cr_next = XW'(f2_c1_reg) - XW'(f2_c2_reg);
    assign tn_next = XW'(f2_t1_reg) - XW'(f2_t2_reg);
    assign un_next = XW'(f2_u1_reg) - XW'(f2_u2_reg);
    assign cr_neg  = -cr_next;
    assign cr_abs  = cr_next[XW-1] ? cr_neg[LW-1:0] : cr_next[LW-1:0];

    assign degen_next = (CW'(len_a) <= CW'(min_length_sq)) ||
                        (CW'(len_b) <= CW'(min_length_sq)) ||
                        (CW'(cr_abs) <= CW'(min_cross_abs));

    always_ff @(posedge aclk) begin
        if (adv) begin
            f1_dax_reg <= DW'(s_a_end_x) - DW'(s_a_start_x);
            f1_day_reg <= DW'(s_a_end_y) - DW'(s_a_start_y);
            f1_dbx_reg <= DW'(s_b_end_x) - DW'(s_b_start_x);
            f1_dby_reg <= DW'(s_b_end_y) - DW'(s_b_start_y);
            f1_dx_reg  <= DW'(s_a_start_x) - DW'(s_b_start_x);
            f1_dy_reg  <= DW'(s_a_start_y) - DW'(s_b_start_y);
            f1_ax0_reg <= s_a_start_x;
            f1_ay0_reg <= s_a_start_y;

            f2_sqax_reg <= sqax_full[2*W:0];
            f2_sqay_reg <= sqay_full[2*W:0];
            f2_sqbx_reg <= sqbx_full[2*W:0];
            f2_sqby_reg <= sqby_full[2*W:0];
            f2_c1_reg   <= f1_dax_reg * f1_dby_reg;
            f2_c2_reg   <= f1_dbx_reg * f1_day_reg;
            f2_t1_reg   <= f1_dbx_reg * f1_dy_reg;
            f2_t2_reg   <= f1_dx_reg * f1_dby_reg;
            f2_u1_reg   <= f1_dax_reg * f1_dy_reg;
            f2_u2_reg   <= f1_dx_reg * f1_day_reg;
            f2_ax0_reg  <= f1_ax0_reg;
            f2_ay0_reg  <= f1_ay0_reg;
            f2_dax_reg  <= f1_dax_reg;
            f2_day_reg  <= f1_day_reg;

            f3_cr_reg    <= cr_next;
            f3_tn_reg    <= tn_next;
            f3_un_reg    <= un_next;
            f3_ax0_reg   <= f2_ax0_reg;
            f3_ay0_reg   <= f2_ay0_reg;
            f3_dax_reg   <= f2_dax_reg;
            f3_day_reg   <= f2_day_reg;
            f3_degen_reg <= degen_next;
        end
    end

    assign q_valid = f3_v_reg;
    assign e_ax0   = f3_ax0_reg;
    assign e_ay0   = f3_ay0_reg;
    assign e_dax   = f3_dax_reg;
    assign e_day   = f3_day_reg;
    assign e_cr    = f3_cr_reg;
    assign e_tn    = f3_tn_reg;
    assign e_un    = f3_un_reg;
    assign e_degen = f3_degen_reg;

endmodule

`default_nettype wire

// ===== design/segi_queue.sv =====
// Small register queue between the front and back parts.
`default_nettype none

module segi_queue #(
    parameter int DW = 8
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [DW-1:0] in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [DW-1:0]      out_data
);
    import segi_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    logic [DW-1:0] mem_reg [0:QUEUE_DEPTH-1];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0] count_reg;
    logic          push, pop;

    assign in_ready  = count_reg != NW'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= in_data;
    end

endmodule

`default_nettype wire

// ===== design/segi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with an overflow flag.
`default_nettype none

module segi_div #(
    parameter int NW = 54,
    parameter int DW = 36,
    parameter int TW = 1
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         en,
    input  wire logic                         in_valid,
    input  wire logic [NW-1:0]                in_n,
    input  wire logic [DW-1:0]                in_d,
    input  wire logic [TW-1:0]                in_tag,
    output logic                              out_valid,
    output logic [segi_pkg::QUOT_W-1:0]       out_q,
    output logic                              out_ovf,
    output logic [TW-1:0]                     out_tag
);
    import segi_pkg::*;

    localparam int QB = QUOT_W;
    localparam int NP = (NW > QB) ? NW : QB + 1;
    localparam int HW = NP - QB;
    localparam int RW = (HW > DW + 1) ? HW : DW + 1;

    logic [RW-1:0] r_reg   [0:QB];
    logic [QB-1:0] nlo_reg [0:QB];
    logic [QB-1:0] q_reg   [0:QB];
    logic [DW-1:0] d_reg   [0:QB];
    logic [TW-1:0] tag_reg [0:QB];
    logic          ovf_reg [0:QB];
    logic          v_reg   [0:QB];

    logic [NP-1:0] n_ext;
    logic [RW-1:0] hi0;

    assign n_ext = NP'(in_n);
    assign hi0   = RW'(n_ext[NP-1:QB]);

    // Stage 0: if the top part already reaches the divisor the quotient needs
    // more than QB bits and the result saturates.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]   <= hi0;
            ovf_reg[0] <= hi0 >= RW'(in_d);
            nlo_reg[0] <= n_ext[QB-1:0];
            q_reg[0]   <= '0;
            d_reg[0]   <= in_d;
            tag_reg[0] <= in_tag;
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_stage
        logic [RW-1:0] rs;
        logic          ge;

        assign rs = {r_reg[k-1][RW-2:0], nlo_reg[k-1][QB-k]};
        assign ge = rs >= RW'(d_reg[k-1]);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[k]   <= ge ? rs - RW'(d_reg[k-1]) : rs;
                q_reg[k]   <= {q_reg[k-1][QB-2:0], ge};
                nlo_reg[k] <= nlo_reg[k-1];
                d_reg[k]   <= d_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    assign out_valid = v_reg[QB];
    assign out_q     = q_reg[QB];
    assign out_ovf   = ovf_reg[QB];
    assign out_tag   = tag_reg[QB];

endmodule

`default_nettype wire

// ===== design/segi_back.sv =====
// Back part: range tests, point numerators, division and saturation of the result.
`default_nettype none

module segi_back #(
    parameter int W = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic signed [W-1:0]      e_ax0,
    input  wire logic signed [W-1:0]      e_ay0,
    input  wire logic signed [W:0]        e_dax,
    input  wire logic signed [W:0]        e_day,
    input  wire logic signed [2*W+2:0]    e_cr,
    input  wire logic signed [2*W+2:0]    e_tn,
    input  wire logic signed [2*W+2:0]    e_un,
    input  wire logic                     e_degen,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output segi_pkg::status_t             m_status,
    output logic signed [31:0]            m_cross_x,
    output logic signed [31:0]            m_cross_y
);
    import segi_pkg::*;

    localparam int XW = 2 * W + 3;
    localparam int MW = 3 * W + 4;
    localparam int NW = MW + 2;
    localparam int DW = XW + 1;
    localparam int SW = QUOT_W + 2;
    localparam int TXW = W + 3;
    localparam int TYW = W + 1;

    logic en;

    // Stage B1: item taken from the queue.
    logic                 b1_v_reg;
    logic signed [W-1:0]  b1_ax0_reg, b1_ay0_reg;
    logic signed [W:0]    b1_dax_reg, b1_day_reg;
    logic signed [XW-1:0] b1_cr_reg, b1_tn_reg, b1_un_reg;
    logic                 b1_degen_reg;

    // Stage B2: point numerators and status.
    logic                 b2_v_reg;
    logic signed [MW-1:0] b2_px_reg, b2_py_reg;
    logic [XW-1:0]        b2_abs_cr_reg;
    logic                 b2_cr_neg_reg;
    status_t              b2_status_reg;
    logic signed [W-1:0]  b2_ax0_reg, b2_ay0_reg;

    // Stage B3: dividend and divisor.
    logic                 b3_v_reg;
    logic [NW-1:0]        b3_nx_reg, b3_ny_reg;
    logic [DW-1:0]        b3_d_reg;
    logic                 b3_negx_reg, b3_negy_reg;
    status_t              b3_status_reg;
    logic signed [W-1:0]  b3_ax0_reg, b3_ay0_reg;

    // Output register.
    logic                 m_valid_reg;
    status_t              m_status_reg;
    logic signed [31:0]   m_cross_x_reg, m_cross_y_reg;

    logic [XW-1:0]        abs_tn, abs_un, abs_cr, neg_tn, neg_un, neg_cr;
    logic                 in_t, in_u;
    status_t              status_next;
    logic [MW-1:0]        neg_px, neg_py, mag_px, mag_py;

    logic                 dx_valid, dy_valid, x_ovf, y_ovf;
    logic [QUOT_W-1:0]    x_q, y_q;
    logic [TXW-1:0]       x_tag;
    logic [TYW-1:0]       y_tag;
    logic signed [31:0]   cx_next, cy_next;

    function automatic logic signed [31:0] place(
        input logic signed [W-1:0] base,
        input logic [QUOT_W-1:0]   q,
        input logic                ovf,
        input logic                neg
    );
        logic signed [SW-1:0] b;
        logic signed [SW-1:0] qs;
        logic signed [SW-1:0] v;
        logic                 big;
        b   = SW'(base);
        qs  = signed'({2'b00, q});
        v   = neg ? b - qs : b + qs;
        big = ovf || (q > BIG_LIMIT);
        if (big) begin
            place = neg ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end else if (v[SW-1:31] != {(SW-31){v[31]}}) begin
            place = v[SW-1] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end else begin
            place = v[31:0];
        end
    endfunction

    assign en       = !m_valid_reg || m_ready;
    assign in_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_v_reg    <= 1'b0;
            b2_v_reg    <= 1'b0;
            b3_v_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            b1_v_reg    <= in_valid;
            b2_v_reg    <= b1_v_reg;
            b3_v_reg    <= b2_v_reg;
            m_valid_reg <= dx_valid;
        end
    end

    // A parameter lies in [0,1] when its numerator is zero, or has the sign
    // of the cross product and no larger magnitude.
    assign neg_tn = -b1_tn_reg;
    assign neg_un = -b1_un_reg;
    assign neg_cr = -b1_cr_reg;
    assign abs_tn = b1_tn_reg[XW-1] ? neg_tn : b1_tn_reg;
    assign abs_un = b1_un_reg[XW-1] ? neg_un : b1_un_reg;
    assign abs_cr = b1_cr_reg[XW-1] ? neg_cr : b1_cr_reg;
    assign in_t = (b1_tn_reg == '0) ||
                  ((b1_tn_reg[XW-1] == b1_cr_reg[XW-1]) && (abs_tn <= abs_cr));
    assign in_u = (b1_un_reg == '0) ||
                  ((b1_un_reg[XW-1] == b1_cr_reg[XW-1]) && (abs_un <= abs_cr));

    always_comb begin
        if (b1_degen_reg)    status_next = ST_NONE;
        else if (in_t && in_u) status_next = ST_CROSS;
        else                 status_next = ST_OUTSIDE;
    end

    assign neg_px = -b2_px_reg;
    assign neg_py = -b2_py_reg;
    assign mag_px = b2_px_reg[MW-1] ? neg_px : b2_px_reg;
    assign mag_py = b2_py_reg[MW-1] ? neg_py : b2_py_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            b1_ax0_reg   <= e_ax0;
            b1_ay0_reg   <= e_ay0;
            b1_dax_reg   <= e_dax;
            b1_day_reg   <= e_day;
            b1_cr_reg    <= e_cr;
            b1_tn_reg    <= e_tn;
            b1_un_reg    <= e_un;
            b1_degen_reg <= e_degen;

            b2_px_reg     <= b1_tn_reg * b1_dax_reg;
            b2_py_reg     <= b1_tn_reg * b1_day_reg;
            b2_abs_cr_reg <= abs_cr;
            b2_cr_neg_reg <= b1_cr_reg[XW-1];
            b2_status_reg <= status_next;
            b2_ax0_reg    <= b1_ax0_reg;
            b2_ay0_reg    <= b1_ay0_reg;

            // Rounding to nearest, ties away from zero: (2|p| + |c|) / (2|c|).
            b3_nx_reg     <= {1'b0, mag_px, 1'b0} + NW'(b2_abs_cr_reg);
            b3_ny_reg     <= {1'b0, mag_py, 1'b0} + NW'(b2_abs_cr_reg);
            b3_d_reg      <= {b2_abs_cr_reg, 1'b0};
            b3_negx_reg   <= b2_px_reg[MW-1] ^ b2_cr_neg_reg;
            b3_negy_reg   <= b2_py_reg[MW-1] ^ b2_cr_neg_reg;
            b3_status_reg <= b2_status_reg;
            b3_ax0_reg    <= b2_ax0_reg;
            b3_ay0_reg    <= b2_ay0_reg;
        end
    end

    segi_div #(.NW(NW), .DW(DW), .TW(TXW)) u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (b3_v_reg),
        .in_n     (b3_nx_reg),
        .in_d     (b3_d_reg),
        .in_tag   ({b3_status_reg, b3_negx_reg, b3_ax0_reg}),
        .out_valid(dx_valid),
        .out_q    (x_q),
        .out_ovf  (x_ovf),
        .out_tag  (x_tag)
    );

    segi_div #(.NW(NW), .DW(DW), .TW(TYW)) u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (b3_v_reg),
        .in_n     (b3_ny_reg),
        .in_d     (b3_d_reg),
        .in_tag   ({b3_negy_reg, b3_ay0_reg}),
        .out_valid(dy_valid),
        .out_q    (y_q),
        .out_ovf  (y_ovf),
        .out_tag  (y_tag)
    );

    assign cx_next = place(x_tag[W-1:0], x_q, x_ovf, x_tag[W]);
    assign cy_next = place(y_tag[W-1:0], y_q, y_ovf, y_tag[W]);

    always_ff @(posedge aclk) begin
        if (en) begin
            m_status_reg <= x_tag[TXW-1:W+1];
            if (x_tag[TXW-1:W+1] == ST_NONE) begin
                m_cross_x_reg <= '0;
                m_cross_y_reg <= '0;
            end else begin
                m_cross_x_reg <= cx_next;
                m_cross_y_reg <= cy_next;
            end
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_cross_x = m_cross_x_reg;
    assign m_cross_y = m_cross_y_reg;

    // Both dividers run in lock step.
    a_div_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        dx_valid == dy_valid)
        else $error("x and y dividers out of step");

endmodule

`default_nettype wire

// ===== design/segment_intersection.sv =====
// Top level of the segment intersection block.
`default_nettype none

// Two segments A and B arrive as one word of signed Q12.4 endpoints. The block
// reports status 0 when either segment is too short (squared length at or below
// min_length_sq) or the lines are nearly parallel (|cross| at or below
// min_cross_abs), and then both coordinates are zero. Otherwise it gives the
// meeting point of the infinite lines in Q28.4, rounded to nearest with ties away
// from zero and saturated to 32 bits, with status 2 when both segment parameters
// lie in [0,1] and status 1 when they do not. The block takes one word every
// cycle and keeps that rate indefinitely while the result side keeps up. A word
// passes through three front stages that form the differences, products and
// the classification, the four-entry queue, three back stages for the range
// tests and the dividends, 42 stages of the pipelined quotient divider (an
// overflow check, then one quotient bit per stage) and the output register.
// The front and back stall independently; the queue lets the front keep
// accepting while the result side is held, until the queue fills. Configuration
// registers are written through the cfg port, which is always ready, and must
// only be written while no word is in flight.

module segment_intersection #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [segi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [segi_pkg::REG_W-1:0]          cfg_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [COORD_WIDTH-1:0]       s_a_start_x,
    input  wire logic signed [COORD_WIDTH-1:0]       s_a_start_y,
    input  wire logic signed [COORD_WIDTH-1:0]       s_a_end_x,
    input  wire logic signed [COORD_WIDTH-1:0]       s_a_end_y,
    input  wire logic signed [COORD_WIDTH-1:0]       s_b_start_x,
    input  wire logic signed [COORD_WIDTH-1:0]       s_b_start_y,
    input  wire logic signed [COORD_WIDTH-1:0]       s_b_end_x,
    input  wire logic signed [COORD_WIDTH-1:0]       s_b_end_y,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output segi_pkg::status_t                        m_status,
    output logic signed [31:0]                       m_cross_x,
    output logic signed [31:0]                       m_cross_y
);
    import segi_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int XW = 2 * W + 3;
    // Queue word: two bases, two directions, three cross values, degenerate flag.
    localparam int EW = 2 * W + 2 * (W + 1) + 3 * XW + 1;

    logic [REG_W-1:0] min_length_sq_reg, min_cross_abs_reg;

    // The registers accept a write every cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_length_sq_reg <= '0;
            min_cross_abs_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MIN_LENGTH_SQ: min_length_sq_reg <= cfg_data;
                REG_MIN_CROSS_ABS: min_cross_abs_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic                 fq_valid, fq_ready, qb_valid, qb_ready;
    logic signed [W-1:0]  f_ax0, f_ay0, b_ax0, b_ay0;
    logic signed [W:0]    f_dax, f_day, b_dax, b_day;
    logic signed [XW-1:0] f_cr, f_tn, f_un, b_cr, b_tn, b_un;
    logic                 f_degen, b_degen;
    logic [EW-1:0]        q_in, q_out;

    segi_front #(.W(W)) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .min_length_sq(min_length_sq_reg),
        .min_cross_abs(min_cross_abs_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_a_start_x  (s_a_start_x),
        .s_a_start_y  (s_a_start_y),
        .s_a_end_x    (s_a_end_x),
        .s_a_end_y    (s_a_end_y),
        .s_b_start_x  (s_b_start_x),
        .s_b_start_y  (s_b_start_y),
        .s_b_end_x    (s_b_end_x),
        .s_b_end_y    (s_b_end_y),
        .q_valid      (fq_valid),
        .q_ready      (fq_ready),
        .e_ax0        (f_ax0),
        .e_ay0        (f_ay0),
        .e_dax        (f_dax),
        .e_day        (f_day),
        .e_cr         (f_cr),
        .e_tn         (f_tn),
        .e_un         (f_un),
        .e_degen      (f_degen)
    );

    assign q_in = {f_ax0, f_ay0, f_dax, f_day, f_cr, f_tn, f_un, f_degen};

    segi_queue #(.DW(EW)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (fq_valid),
        .in_ready (fq_ready),
        .in_data  (q_in),
        .out_valid(qb_valid),
        .out_ready(qb_ready),
        .out_data (q_out)
    );

    assign {b_ax0, b_ay0, b_dax, b_day, b_cr, b_tn, b_un, b_degen} = q_out;

    segi_back #(.W(W)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (qb_valid),
        .in_ready (qb_ready),
        .e_ax0    (b_ax0),
        .e_ay0    (b_ay0),
        .e_dax    (b_dax),
        .e_day    (b_day),
        .e_cr     (b_cr),
        .e_tn     (b_tn),
        .e_un     (b_un),
        .e_degen  (b_degen),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_status (m_status),
        .m_cross_x(m_cross_x),
        .m_cross_y(m_cross_y)
    );

    // A degenerate or parallel result carries a zero point.
    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_NONE) |-> (m_cross_x == '0 && m_cross_y == '0))
        else $error("status none with nonzero point");

    a_status_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_NONE || m_status == ST_OUTSIDE ||
                     m_status == ST_CROSS))
        else $error("illegal status code");

    // A full queue always has a word to offer.
    a_queue_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !fq_ready |-> qb_valid)
        else $error("queue full but empty");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the segment intersection block.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import segi_pkg::*;

    // One input word: both segments, endpoints in signed Q12.4.
    typedef struct packed {
        logic signed [15:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    } seg_pair_t;

    // One result word as the block should report it.
    typedef struct packed {
        status_t            status;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } crossing_t;

    typedef logic signed [127:0] wide_t;

    localparam wide_t QUOT_SAT = wide_t'(1) << 40;
    localparam wide_t POS_SAT  = 128'sd2147483647;
    localparam wide_t NEG_SAT  = -128'sd2147483648;
    localparam int    WATCHDOG = 20000;
    localparam int    HOLD_LEN = 400;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    seg_pair_t s_word = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    status_t m_status;
    logic signed [31:0] m_cross_x, m_cross_y;

    segment_intersection #(.COORD_WIDTH(16)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_a_start_x(s_word.ax0), .s_a_start_y(s_word.ay0),
        .s_a_end_x(s_word.ax1), .s_a_end_y(s_word.ay1),
        .s_b_start_x(s_word.bx0), .s_b_start_y(s_word.by0),
        .s_b_end_x(s_word.bx1), .s_b_end_y(s_word.by1),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_cross_x(m_cross_x), .m_cross_y(m_cross_y)
    );

    always #6 aclk = ~aclk;

    // Words waiting to be offered, and results the block still owes us.
    seg_pair_t pending_pairs[$];
    crossing_t expected_crossings[$];

    // Our own copy of the two threshold registers.
    logic [REG_W-1:0] min_len_sq_copy = '0;
    logic [REG_W-1:0] min_cross_copy = '0;

    // Idle percentages for each side; the stimulus process changes them per phase.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    int failures = 0;
    int quiet_cycles = 0;
    logic took_word = 1'b0;

    // Base coordinate plus the rounded quotient num/den, ties away from zero.
    // A quotient beyond 2^40 saturates straight toward its own sign.
    function automatic logic signed [31:0] rounded_coord(wide_t base, wide_t num, wide_t den);
        wide_t mag_n, mag_d, quot, sum;
        logic neg;
        mag_n = (num < 0) ? -num : num;
        mag_d = (den < 0) ? -den : den;
        quot = (2 * mag_n + mag_d) / (2 * mag_d);
        neg = (num < 0) != (den < 0);
        if (quot > QUOT_SAT) begin
            sum = neg ? NEG_SAT : POS_SAT;
        end else begin
            sum = neg ? base - quot : base + quot;
            if (sum > POS_SAT) sum = POS_SAT;
            if (sum < NEG_SAT) sum = NEG_SAT;
        end
        return sum[31:0];
    endfunction

    // A segment parameter lies in [0,1] when its numerator is zero, or has the
    // sign of the cross product and no larger magnitude.
    function automatic logic param_in_unit(wide_t num, wide_t den);
        wide_t mag_n, mag_d;
        mag_n = (num < 0) ? -num : num;
        mag_d = (den < 0) ? -den : den;
        if (num == 0) return 1'b1;
        return ((num < 0) == (den < 0)) && (mag_n <= mag_d);
    endfunction

    function automatic crossing_t predict_crossing(seg_pair_t p);
        wide_t dax, day, dbx, dby, dx, dy, len_a, len_b, cr, tn, un, mag_cr;
        crossing_t r;
        dax = wide_t'(p.ax1) - wide_t'(p.ax0);
        day = wide_t'(p.ay1) - wide_t'(p.ay0);
        dbx = wide_t'(p.bx1) - wide_t'(p.bx0);
        dby = wide_t'(p.by1) - wide_t'(p.by0);
        dx = wide_t'(p.ax0) - wide_t'(p.bx0);
        dy = wide_t'(p.ay0) - wide_t'(p.by0);
        len_a = dax * dax + day * day;
        len_b = dbx * dbx + dby * dby;
        cr = dax * dby - dbx * day;
        mag_cr = (cr < 0) ? -cr : cr;
        r = '0;
        r.status = ST_NONE;
        if (len_a <= wide_t'(min_len_sq_copy) || len_b <= wide_t'(min_len_sq_copy) ||
            mag_cr <= wide_t'(min_cross_copy))
            return r;
        tn = dbx * dy - dx * dby;
        un = dax * dy - dx * day;
        r.status = (param_in_unit(tn, cr) && param_in_unit(un, cr)) ? ST_CROSS : ST_OUTSIDE;
        r.x = rounded_coord(wide_t'(p.ax0), tn * dax, cr);
        r.y = rounded_coord(wide_t'(p.ay0), tn * day, cr);
        return r;
    endfunction

    // Everything that happens at the rising edge: acceptance on all three
    // channels, the result check, and the watchdog.
    always @(posedge aclk) begin
        crossing_t want;
        logic progress;
        logic took;
        progress = 1'b0;
        took = 1'b0;
        if (aresetn && cfg_valid && cfg_ready) begin
            progress = 1'b1;
            if (cfg_index == REG_MIN_LENGTH_SQ) min_len_sq_copy <= cfg_data;
            else if (cfg_index == REG_MIN_CROSS_ABS) min_cross_copy <= cfg_data;
        end
        if (aresetn && s_valid && s_ready) begin
            progress = 1'b1;
            took = 1'b1;
            expected_crossings.push_back(predict_crossing(s_word));
        end
        took_word <= took;
        if (aresetn && m_valid && m_ready) begin
            progress = 1'b1;
            if (expected_crossings.size() == 0) begin
                $error("result word with nothing expected: status %0d x %0d y %0d",
                       m_status, m_cross_x, m_cross_y);
                failures++;
            end else begin
                want = expected_crossings.pop_front();
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    failures++;
                end
                if (m_cross_x !== want.x) begin
                    $error("cross_x: expected %0d, got %0d", want.x, m_cross_x);
                    failures++;
                end
                if (m_cross_y !== want.y) begin
                    $error("cross_y: expected %0d, got %0d", want.y, m_cross_y);
                    failures++;
                end
            end
        end
        // Only count stalled cycles while some work is outstanding.
        if (progress || (pending_pairs.size() == 0 && expected_crossings.size() == 0 &&
                         !s_valid)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Sender: at the falling edge, hold the current word until it is taken,
    // then either idle or present the next one from the queue.
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || took_word)) begin
            if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_word <= pending_pairs.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus an occasional long hold-off so the internal
    // queue fills and the block has to push back on its input.
    always @(negedge aclk) begin
        if (hold_requests != hold_seen) begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_LEN;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic seg_pair_t make_pair(int ax0, int ay0, int ax1, int ay1,
                                            int bx0, int by0, int bx1, int by1);
        seg_pair_t p;
        p.ax0 = ax0[15:0]; p.ay0 = ay0[15:0]; p.ax1 = ax1[15:0]; p.ay1 = ay1[15:0];
        p.bx0 = bx0[15:0]; p.by0 = by0[15:0]; p.bx1 = bx1[15:0]; p.by1 = by1[15:0];
        return p;
    endfunction

    function automatic int rand_coord(int span);
        return $urandom_range(2 * span) - span;
    endfunction

    // Random pairs of several flavors: small segments that often cross, fully
    // random words, nearly parallel lines that meet far away, and segments
    // that share an endpoint.
    function automatic seg_pair_t random_pair();
        seg_pair_t p;
        int kind, dxa, dya, ox, oy;
        kind = $urandom_range(99);
        if (kind < 40) begin
            p = make_pair(rand_coord(300), rand_coord(300), rand_coord(300), rand_coord(300),
                          rand_coord(300), rand_coord(300), rand_coord(300), rand_coord(300));
        end else if (kind < 70) begin
            p = seg_pair_t'({$urandom, $urandom, $urandom, $urandom});
        end else if (kind < 90) begin
            dxa = rand_coord(16000);
            dya = rand_coord(16000);
            ox = rand_coord(16000);
            oy = rand_coord(16000);
            p = make_pair(ox, oy, ox + dxa, oy + dya,
                          ox + rand_coord(16000), oy + rand_coord(16000), 0, 0);
            p.bx1 = p.bx0 + 16'(dxa + rand_coord(2));
            p.by1 = p.by0 + 16'(dya + rand_coord(2));
        end else begin
            p = seg_pair_t'({$urandom, $urandom, $urandom, $urandom});
            p.bx0 = p.ax1;
            p.by0 = p.ay1;
        end
        return p;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] value);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Wait for every word to go out and every result to come back, then let
    // the pipeline drain well past its latency before touching the registers.
    task automatic drain();
        do @(posedge aclk);
        while (pending_pairs.size() != 0 || expected_crossings.size() != 0 || s_valid);
        repeat (80) @(posedge aclk);
    endtask

    task automatic run_phase(logic [REG_W-1:0] len_th, logic [REG_W-1:0] cross_th,
                             int unsigned idle_s, int unsigned stall_r, int count);
        write_reg(REG_MIN_LENGTH_SQ, len_th);
        write_reg(REG_MIN_CROSS_ABS, cross_th);
        send_idle_pct = idle_s;
        recv_stall_pct = stall_r;
        for (int i = 0; i < count; i++) pending_pairs.push_back(random_pair());
        drain();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed words with the thresholds at their reset value of zero.
        pending_pairs.push_back(make_pair(-32768, -32768, -32768, -32768,
                                          -32768, -32768, -32768, -32768));
        pending_pairs.push_back(make_pair(32767, 32767, 32767, 32767,
                                          32767, 32767, 32767, 32767));
        // Full-range diagonals crossing in the middle.
        pending_pairs.push_back(make_pair(-32768, -32768, 32767, 32767,
                                          -32768, 32767, 32767, -32768));
        pending_pairs.push_back(make_pair(32767, -32768, -32768, 32767,
                                          -32768, -32768, 32767, 32767));
        // Zero-length segment A.
        pending_pairs.push_back(make_pair(5, 5, 5, 5, 0, 0, 16, 16));
        // Parallel, and collinear overlapping.
        pending_pairs.push_back(make_pair(0, 0, 160, 0, 0, 16, 160, 16));
        pending_pairs.push_back(make_pair(0, 0, 160, 0, 32, 0, 320, 0));
        // Plain crossing, touching at t = 0, touching at t = 1, missing.
        pending_pairs.push_back(make_pair(0, 0, 32, 32, 0, 32, 32, 0));
        pending_pairs.push_back(make_pair(16, 16, 64, 16, 16, 0, 16, 64));
        pending_pairs.push_back(make_pair(0, 0, 32, 0, 32, -16, 32, 16));
        pending_pairs.push_back(make_pair(0, 0, 16, 0, 64, -16, 64, 16));
        // Cross product of one: the quotient runs far past 2^40 and saturates.
        pending_pairs.push_back(make_pair(-32768, -32768, 32767, -32767,
                                          -32768, 32766, 32766, 32767));
        // Cross product of one with a meeting point beyond 32 bits.
        pending_pairs.push_back(make_pair(-32768, 0, 32767, 1, -32768, 2, 32766, 3));
        pending_pairs.push_back(make_pair(0, 0, 1, 0, 0, 16, 32767, 17));
        pending_pairs.push_back(make_pair(-100, -100, -20, -30, -100, -30, -20, -100));
        pending_pairs.push_back(make_pair(0, 0, 3, 1, 0, 1, 3, 0));
        drain();

        run_phase(34'd16, 34'd16, 75, 0, 300);
        // The receiver holds off for a long stretch while the sender keeps going.
        hold_requests = hold_requests + 1;
        run_phase(34'd0, 34'd0, 0, 75, 300);
        // Largest thresholds: every pair is degenerate, then every pair parallel.
        run_phase({REG_W{1'b1}}, 34'd0, 22, 22, 100);
        run_phase(34'd0, 34'h2_0000_0000, 0, 0, 100);
        run_phase(34'd1000, 34'd5000, 22, 22, 300);
        run_phase(34'd0, 34'd1, 0, 0, 100);

        repeat (100) @(posedge aclk);
        if (failures == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

`default_nettype wire
